>>> src/cpd_pkg.sv
// Package for the card presence detector: shared constants, register indexes,
// operation codes, the controller state type and the averaging store command.
// No dependencies; every other file of the block but cpd_sdiv imports it.
package cpd_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int AVG_DEPTH_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    // Per-mil scaling and field widths.
    localparam int PERMIL         = 1000;
    localparam int PERMIL_BITS    = 10;
    localparam int RISE_BITS      = 11;
    localparam int DEV_BITS       = 16;
    localparam int CFG_BITS       = 10;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [DEV_BITS-1:0] DEV_MAX = 16'hFFFF;

    // Register reset values.
    localparam logic [CFG_BITS-1:0] THRESHOLD_RESET  = 10'd5;
    localparam logic [CFG_BITS-1:0] RISE_LIMIT_RESET = 10'd20;

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RISE_LIMIT = 2'd1;

    // Operation codes carried with each input item.
    localparam logic OP_CAL    = 1'b0;
    localparam logic OP_DETECT = 1'b1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CAL_END,
        ST_MUL,
        ST_LAUNCH,
        ST_DIV_WAIT,
        ST_SELECT,
        ST_FEED,
        ST_AVG_LAUNCH,
        ST_AVG_WAIT,
        ST_DONE
    } cpd_state_t;

    // Command to the averaging store.
    typedef struct packed {
        logic push;
        logic fill;
    } store_cmd_t;

endpackage

>>> src/cpd_sdiv.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// The caller guarantees that the quotient fits in QW bits. Uses no package items.
module cpd_sdiv #(
    parameter int DW = 22,
    parameter int VW = 12,
    parameter int QW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [QW-1:0] quotient
);

    localparam int CNTW = $clog2(QW + 1);

    logic [VW-1:0]   rem_reg;
    logic [QW-1:0]   shf_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;

    logic [DW-1:0]   hi_bits;
    logic [VW:0]     cand;
    logic [VW+1:0]   trial;
    logic            fits;

    // Trial subtraction of the divisor from the partial remainder.
    always_comb begin
        hi_bits = dividend >> QW;
        cand    = {rem_reg, shf_reg[QW-1]};
        trial   = {1'b0, cand} - {2'b00, divisor};
        fits    = ~trial[VW+1];
    end

    // Run control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(QW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and dividend/quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= hi_bits[VW-1:0];
            shf_reg <= dividend[QW-1:0];
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[VW-1:0] : cand[VW-1:0];
            shf_reg <= {shf_reg[QW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = shf_reg;

endmodule

>>> src/cpd_store.sv
// Averaging store of the detector: a shift line of the last fed values and
// their running sum. Depends on cpd_pkg for the command struct.
module cpd_store #(
    parameter int DEPTH       = 8,
    parameter int SAMPLE_BITS = 12,
    parameter int SSW         = SAMPLE_BITS + $clog2(DEPTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cpd_pkg::store_cmd_t     cmd,
    input  logic [SAMPLE_BITS-1:0]  value,
    output logic [SSW-1:0]          sum
);

    import cpd_pkg::*;

    logic [SAMPLE_BITS-1:0] store_reg [DEPTH];
    logic [SSW-1:0]         sum_reg;

    // Fill sets every entry to the new baseline; push drops the oldest entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                store_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (cmd.fill) begin
            for (int i = 0; i < DEPTH; i++) begin
                store_reg[i] <= value;
            end
            sum_reg <= SSW'(value) * SSW'(DEPTH);
        end else if (cmd.push) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                store_reg[i] <= store_reg[i+1];
            end
            store_reg[DEPTH-1] <= value;
            sum_reg <= sum_reg - SSW'(store_reg[0]) + SSW'(value);
        end
    end

    assign sum = sum_reg;

endmodule

>>> src/card_presence_detector.sv
// Card presence detector: calibrated baseline tracking and per-mil deviation.
// A calibration item that does not end a run goes straight to the output register;
// the last item of a run and every detect item wait for the serial dividers.
// One item at a time, the next can be taken the cycle after the result is loaded.
// aresetn is synchronous: state clears, registers reload.
module card_presence_detector #(
    parameter int   AVG_DEPTH   = cpd_pkg::AVG_DEPTH_DEF,
    parameter int   SAMPLE_BITS = cpd_pkg::SAMPLE_BITS_DEF,
    localparam int  IN_W        = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int  OUT_W       = ((SAMPLE_BITS + cpd_pkg::DEV_BITS + 2 + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [IN_W-1:0]                     s_tdata,  // sample
    input  logic                                s_tuser,  // operation
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // card_found, baseline_level, deviation_permil, calibrated
    output logic [OUT_W-1:0]                    m_tdata,
    // Register writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [cpd_pkg::CFG_BITS-1:0]        cfg_data
);

    import cpd_pkg::*;

    localparam int SSW  = SAMPLE_BITS + $clog2(AVG_DEPTH);
    localparam int CSW  = SAMPLE_BITS + $clog2(AVG_DEPTH + 2);
    localparam int CNTW = $clog2(AVG_DEPTH + 3);
    localparam int DVW  = $clog2(AVG_DEPTH + 1);
    localparam int PDW  = SAMPLE_BITS + PERMIL_BITS;
    localparam int PFW  = SAMPLE_BITS + RISE_BITS;
    localparam int FQW  = SAMPLE_BITS + 2;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam logic [CNTW-1:0]        CAL_LAST   = CNTW'(AVG_DEPTH + 1);

    cpd_state_t state_reg, state_next;

    logic [CFG_BITS-1:0]    thr_reg, lim_reg;
    logic                   op_reg;
    logic [SAMPLE_BITS-1:0] samp_reg;
    logic [SAMPLE_BITS-1:0] baseline_reg;
    logic [CNTW-1:0]        cal_count_reg;
    logic [CSW-1:0]         cal_sum_reg;
    logic [SAMPLE_BITS-1:0] cal_max_reg, cal_min_reg;
    logic                   cal_done_reg;
    logic [CSW-1:0]         cal_num_reg;
    logic [SAMPLE_BITS-1:0] diff_reg;
    logic                   above_reg, below_reg, bzero_reg;
    logic [PDW-1:0]         prod_dev_reg;
    logic [PFW-1:0]         prod_fed_reg;
    logic                   dev_sat_reg;
    logic [DEV_BITS-1:0]    dev_reg;
    logic                   found_reg;
    logic [SAMPLE_BITS-1:0] fed_reg;
    logic                   m_valid_reg;
    logic [OUT_W-1:0]       m_data_reg, m_data_next;

    logic                   in_accept;
    logic                   div_start, avg_start, out_load;
    store_cmd_t             store_cmd;
    logic [SAMPLE_BITS-1:0] store_value;
    logic [SSW-1:0]         store_sum;
    logic [CSW-1:0]         avg_dividend;
    logic                   dev_busy, fed_busy, avg_busy;
    logic [DEV_BITS-1:0]    dev_q, dev_value;
    logic [FQW-1:0]         fed_q;
    logic [SAMPLE_BITS-1:0] avg_q;

    assign in_accept = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RESET;
            lim_reg <= RISE_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_THRESHOLD:  thr_reg <= cfg_data;
                REG_RISE_LIMIT: lim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and control strobes.
    always_comb begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        div_start      = 1'b0;
        avg_start      = 1'b0;
        out_load       = 1'b0;
        store_cmd.push = 1'b0;
        store_cmd.fill = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                if (op_reg == OP_CAL) begin
                    state_next = (cal_count_reg == CAL_LAST) ? ST_CAL_END : ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_CAL_END:  state_next = ST_AVG_LAUNCH;
            ST_MUL:      state_next = ST_LAUNCH;
            ST_LAUNCH: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!dev_busy && !fed_busy) begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:   state_next = ST_FEED;
            ST_FEED: begin
                store_cmd.push = 1'b1;
                state_next     = ST_AVG_LAUNCH;
            end
            ST_AVG_LAUNCH: begin
                avg_start  = 1'b1;
                state_next = ST_AVG_WAIT;
            end
            ST_AVG_WAIT: begin
                if (!avg_busy) begin
                    store_cmd.fill = (op_reg == OP_CAL);
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Saturated deviation once both divisions have finished.
    assign dev_value = (bzero_reg || dev_sat_reg) ? DEV_MAX : dev_q;

    // Store operand and averaging dividend.
    assign store_value  = store_cmd.fill ? avg_q : fed_reg;
    assign avg_dividend = (op_reg == OP_CAL) ? cal_num_reg : CSW'(store_sum);

    // Calibration accumulators, baseline and done flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg  <= '0;
            cal_count_reg <= '0;
            cal_sum_reg   <= '0;
            cal_max_reg   <= '0;
            cal_min_reg   <= SAMPLE_MAX;
            cal_done_reg  <= 1'b0;
        end else begin
            if (state_reg == ST_PREP && op_reg == OP_CAL) begin
                cal_count_reg <= cal_count_reg + 1'b1;
                cal_sum_reg   <= cal_sum_reg + CSW'(samp_reg);
                if (samp_reg > cal_max_reg) begin
                    cal_max_reg <= samp_reg;
                end
                if (samp_reg < cal_min_reg) begin
                    cal_min_reg <= samp_reg;
                end
            end
            if (state_reg == ST_CAL_END) begin
                cal_count_reg <= '0;
                cal_sum_reg   <= '0;
                cal_max_reg   <= '0;
                cal_min_reg   <= SAMPLE_MAX;
                cal_done_reg  <= 1'b1;
            end
            if (state_reg == ST_AVG_WAIT && !avg_busy) begin
                baseline_reg <= avg_q;
            end
        end
    end

    // Per-item datapath registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_reg   <= s_tuser;
            samp_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        case (state_reg)
            ST_PREP: begin
                found_reg <= 1'b0;
                dev_reg   <= '0;
                above_reg <= samp_reg > baseline_reg;
                below_reg <= samp_reg < baseline_reg;
                bzero_reg <= baseline_reg == '0;
                diff_reg  <= (samp_reg > baseline_reg) ? samp_reg - baseline_reg
                                                       : baseline_reg - samp_reg;
            end
            ST_CAL_END: begin
                cal_num_reg <= cal_sum_reg - CSW'(cal_max_reg) - CSW'(cal_min_reg);
            end
            ST_MUL: begin
                prod_dev_reg <= PDW'(diff_reg) * PDW'(PERMIL);
                prod_fed_reg <= PFW'(baseline_reg) * (PFW'(PERMIL) + PFW'(lim_reg));
            end
            ST_LAUNCH: begin
                // The quotient overflows 16 bits when the product reaches b * 2^16.
                dev_sat_reg <= {{(DEV_BITS - PERMIL_BITS){1'b0}}, prod_dev_reg}
                               >= {baseline_reg, {DEV_BITS{1'b0}}};
            end
            ST_SELECT: begin
                dev_reg <= dev_value;
                if (above_reg && dev_value > DEV_BITS'(lim_reg)) begin
                    found_reg <= 1'b0;
                    fed_reg   <= (fed_q > FQW'(SAMPLE_MAX)) ? SAMPLE_MAX
                                                           : fed_q[SAMPLE_BITS-1:0];
                end else begin
                    found_reg <= dev_value >= DEV_BITS'(thr_reg);
                    fed_reg   <= below_reg ? baseline_reg - 1'b1 : samp_reg;
                end
            end
            default: ;
        endcase
    end

    // Result word.
    always_comb begin
        m_data_next                                      = '0;
        m_data_next[0]                                   = found_reg;
        m_data_next[SAMPLE_BITS:1]                       = baseline_reg;
        m_data_next[SAMPLE_BITS+DEV_BITS:SAMPLE_BITS+1]  = dev_reg;
        m_data_next[SAMPLE_BITS+DEV_BITS+1]              = cal_done_reg;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Deviation divider: |s - b| * 1000 / b.
    cpd_sdiv #(
        .DW (PDW),
        .VW (SAMPLE_BITS),
        .QW (DEV_BITS)
    ) u_dev_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_dev_reg),
        .divisor  (baseline_reg),
        .busy     (dev_busy),
        .quotient (dev_q)
    );

    // Raised value divider: b * (1000 + limit) / 1000.
    cpd_sdiv #(
        .DW (PFW),
        .VW (PERMIL_BITS),
        .QW (FQW)
    ) u_fed_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_fed_reg),
        .divisor  (PERMIL_BITS'(PERMIL)),
        .busy     (fed_busy),
        .quotient (fed_q)
    );

    // Averaging divider, shared by calibration and store updates.
    cpd_sdiv #(
        .DW (CSW),
        .VW (DVW),
        .QW (SAMPLE_BITS)
    ) u_avg_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (avg_start),
        .dividend (avg_dividend),
        .divisor  (DVW'(AVG_DEPTH)),
        .busy     (avg_busy),
        .quotient (avg_q)
    );

    // Averaging store.
    cpd_store #(
        .DEPTH       (AVG_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SSW         (SSW)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (store_cmd),
        .value   (store_value),
        .sum     (store_sum)
    );

endmodule

>>> src/cpd_checker.sv
// Port-level checker for the card presence detector, bound to the top level.
// Depends on cpd_pkg for field widths.
module cpd_port_props #(
    parameter int  SAMPLE_BITS = cpd_pkg::SAMPLE_BITS_DEF,
    localparam int OUT_W       = ((SAMPLE_BITS + cpd_pkg::DEV_BITS + 2 + 7) / 8) * 8
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [OUT_W-1:0]                    m_tdata
);

    import cpd_pkg::*;

    localparam int CAL_BIT = SAMPLE_BITS + DEV_BITS + 1;

    logic [1:0] pend_reg;
    logic       seen_cal_reg;
    logic       in_acc, out_acc;

    assign in_acc  = s_tvalid & s_tready;
    assign out_acc = m_tvalid & m_tready;

    // Items accepted but not yet delivered, and whether calibration was reported.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg     <= '0;
            seen_cal_reg <= 1'b0;
        end else begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc && m_tdata[CAL_BIT]) begin
                seen_cal_reg <= 1'b1;
            end
        end
    end

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // At most one item in work plus one waiting in the output register.
    a_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("too many items in flight");

    // Every shown result belongs to an accepted item.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result without an accepted item");

    // Once calibration has been reported it stays reported.
    a_cal_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_cal_reg |-> m_tdata[CAL_BIT])
        else $error("calibrated flag dropped");

endmodule

bind card_presence_detector cpd_port_props #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cpd_port_props (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
